### design/ufp_pkg.sv
`timescale 1ns / 1ps
// types, codes and constants shared by the ultrasonic frame parser modules
package ufp_pkg;

	localparam int unsigned TickW = 10;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADSUM  = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic REG_HEADER_TIMEOUT = 1'b0;
	localparam logic REG_BYTE_TIMEOUT   = 1'b1;

	localparam logic [7:0]       HEADER_MARK     = 8'hFF;
	localparam logic [TickW-1:0] TIMEOUT_DEFAULT = 10'd100;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_HIGH   = 3'd2,
		PH_LOW    = 3'd3,
		PH_SUM    = 3'd4
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [7:0]       high_byte;
		logic [7:0]       low_byte;
		logic [TickW-1:0] elapsed;
	} parse_state_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic [15:0] distance;
	} parse_result_t;

endpackage

### design/ultrasonic_frame_parser_core.sv
`timescale 1ns / 1ps
// top level of the ultrasonic frame parser: input stage, parser state, result register
//
//  channel  handshake                  payload
//  in       in_valid / in_ready        op[1:0], rx_byte[7:0]
//  out      out_valid / out_ready      status[1:0], distance[15:0]
//  cfg      cfg_we (no wait)           cfg_index[0], cfg_wdata[9:0]
//
// one operation per cycle while in_ready is high: it is registered at the input, applied
// to the parser state as stage 1 advances; any result enters the output register at that edge
// arst_n clears the state to idle and both timeouts to 100 ticks
// a held result stalls the input stage only when the next operation also yields a result
module ultrasonic_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] distance,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [ufp_pkg::TickW-1:0] cfg_wdata
);

	logic                      v_s1;
	logic [1:0]                op_s1;
	logic [7:0]                byte_s1;
	ufp_pkg::parse_state_t     state_q;
	ufp_pkg::parse_state_t     state_nxt;
	ufp_pkg::parse_result_t    res;
	logic [ufp_pkg::TickW-1:0] header_limit_q;
	logic [ufp_pkg::TickW-1:0] byte_limit_q;
	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [15:0]               distance_q;
	logic                      advance;

	ufp_step u_step (
		.cur          (state_q),
		.op           (op_s1),
		.rx_byte      (byte_s1),
		.header_limit (header_limit_q),
		.byte_limit   (byte_limit_q),
		.nxt          (state_nxt),
		.res          (res)
	);

	// stage 1 moves on unless it would overwrite a result not yet taken
	assign advance  = v_s1 && (!res.valid || !out_valid_q || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= ufp_pkg::PH_IDLE;
			state_q.high_byte <= 8'd0;
			state_q.low_byte  <= 8'd0;
			state_q.elapsed   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_limit_q <= ufp_pkg::TIMEOUT_DEFAULT;
			byte_limit_q   <= ufp_pkg::TIMEOUT_DEFAULT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ufp_pkg::REG_HEADER_TIMEOUT: header_limit_q <= cfg_wdata;
				ufp_pkg::REG_BYTE_TIMEOUT:   byte_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q   <= res.status;
			distance_q <= res.distance;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign distance  = distance_q;

	a_dist_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ufp_pkg::ST_OK |-> distance_q == 16'd0)
		else $error("nonzero distance on a failed attempt");

	a_idle_elapsed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == ufp_pkg::PH_IDLE |-> state_q.elapsed == '0)
		else $error("tick count left over while idle");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> out_valid_q)
		else $error("result not captured");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(status_q) && $stable(distance_q))
		else $error("pending result overwritten");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == ufp_pkg::ST_OK || status_q == ufp_pkg::ST_BADSUM ||
			status_q == ufp_pkg::ST_TIMEOUT))
		else $error("reserved status code");

endmodule

### design/ufp_step.sv
`timescale 1ns / 1ps
// next-state and result logic for one parser operation
module ufp_step (
	input  ufp_pkg::parse_state_t  cur,
	input  logic [1:0]             op,
	input  logic [7:0]             rx_byte,
	input  logic [ufp_pkg::TickW-1:0] header_limit,
	input  logic [ufp_pkg::TickW-1:0] byte_limit,
	output ufp_pkg::parse_state_t  nxt,
	output ufp_pkg::parse_result_t res
);

	logic [ufp_pkg::TickW:0] tick_inc;
	logic [7:0]              sum_calc;

	assign tick_inc = {1'b0, cur.elapsed} + {{ufp_pkg::TickW{1'b0}}, 1'b1};
	assign sum_calc = ufp_pkg::HEADER_MARK + cur.high_byte + cur.low_byte;

	always_comb begin
		nxt          = cur;
		res.valid    = 1'b0;
		res.status   = ufp_pkg::ST_OK;
		res.distance = 16'd0;
		unique case (op)
			ufp_pkg::OP_START: begin
				nxt.phase     = ufp_pkg::PH_HEADER;
				nxt.high_byte = 8'd0;
				nxt.low_byte  = 8'd0;
				nxt.elapsed   = '0;
			end
			ufp_pkg::OP_BYTE: begin
				unique case (cur.phase)
					ufp_pkg::PH_HEADER: begin
						if (rx_byte == ufp_pkg::HEADER_MARK && cur.elapsed < header_limit) begin
							nxt.phase   = ufp_pkg::PH_HIGH;
							nxt.elapsed = '0;
						end
					end
					ufp_pkg::PH_HIGH: begin
						nxt.high_byte = rx_byte;
						nxt.phase     = ufp_pkg::PH_LOW;
						nxt.elapsed   = '0;
					end
					ufp_pkg::PH_LOW: begin
						nxt.low_byte = rx_byte;
						nxt.phase    = ufp_pkg::PH_SUM;
						nxt.elapsed  = '0;
					end
					ufp_pkg::PH_SUM: begin
						nxt.phase   = ufp_pkg::PH_IDLE;
						nxt.elapsed = '0;
						res.valid   = 1'b1;
						if (sum_calc == rx_byte) begin
							res.status   = ufp_pkg::ST_OK;
							res.distance = {cur.high_byte, cur.low_byte};
						end else begin
							res.status = ufp_pkg::ST_BADSUM;
						end
					end
					default: ;
				endcase
			end
			ufp_pkg::OP_TICK: begin
				unique case (cur.phase)
					ufp_pkg::PH_HEADER: begin
						if (tick_inc >= {1'b0, header_limit}) begin
							nxt.phase   = ufp_pkg::PH_IDLE;
							nxt.elapsed = '0;
							res.valid   = 1'b1;
							res.status  = ufp_pkg::ST_TIMEOUT;
						end else begin
							nxt.elapsed = tick_inc[ufp_pkg::TickW-1:0];
						end
					end
					ufp_pkg::PH_HIGH, ufp_pkg::PH_LOW, ufp_pkg::PH_SUM: begin
						if (cur.elapsed >= byte_limit) begin
							nxt.phase   = ufp_pkg::PH_IDLE;
							nxt.elapsed = '0;
							res.valid   = 1'b1;
							res.status  = ufp_pkg::ST_TIMEOUT;
						end else begin
							nxt.elapsed = tick_inc[ufp_pkg::TickW-1:0];
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

endmodule
